FILE: design/cbt_pkg.sv
package cbt_pkg;

  localparam int unsigned CLOCK_W = 32;
  localparam int unsigned BAUD_W = 20;
  localparam int unsigned WORD_W = 15;
  localparam int unsigned DIVSEL_W = 4;

  localparam logic [CLOCK_W-1:0] CLOCK_RESET = 32'd48000000;

  // Search ranges: divider d, prescale index q-1, segment index s-3
  localparam logic [3:0] DIV_LAST = 4'd15;
  localparam logic [4:0] QIDX_LAST = 5'd31;
  localparam logic [3:0] SIDX_LAST = 4'd14;
  localparam logic [1:0] SJW_MAX = 2'd3;

  // Product s*q*(d+1) never exceeds 17*32*16 = 8704
  localparam int unsigned PROD_W = 14;
  // q*(d+1) never exceeds 512
  localparam int unsigned QM_W = 10;

  typedef struct packed {
    logic done;
    logic [CLOCK_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic start;
    logic [CLOCK_W-1:0] dividend;
    logic [BAUD_W-1:0] divisor;
  } div_req_t;

endpackage

FILE: design/cbt_ifs.sv
interface cbt_req_if;
  logic valid;
  logic ready;
  logic [cbt_pkg::BAUD_W-1:0] bit_rate;

  modport source (output valid, output bit_rate, input ready);
  modport sink (input valid, input bit_rate, output ready);
endinterface

interface cbt_res_if;
  logic valid;
  logic ready;
  logic found;
  logic [cbt_pkg::DIVSEL_W-1:0] clock_divider;
  logic [cbt_pkg::WORD_W-1:0] timing_word;

  modport source (output valid, output found, output clock_divider, output timing_word,
                  input ready);
  modport sink (input valid, input found, input clock_divider, input timing_word,
                output ready);
endinterface

FILE: design/can_bit_timing_search.sv
// Flow: a taken request with a nonzero bit rate runs a bit-serial division (32
// steps, then a done strobe), then the search (one candidate per cycle), then
// posts the result; a zero bit rate goes straight to post.
// A new request is taken only in idle, after the previous result has posted;
// a stalled result holds the sequencer in post.
// Reset (rst high, synchronous): idle sequencer, empty result, clock register 48000000.
module can_bit_timing_search (
  input  logic                        clk,
  input  logic                        rst,
  cbt_req_if.sink                     request,
  cbt_res_if.source                   result,
  input  logic                        cfg_we,
  input  logic [cbt_pkg::CLOCK_W-1:0] cfg_data
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DIV    = 2'd1;
  localparam logic [1:0] ST_SEARCH = 2'd2;
  localparam logic [1:0] ST_POST   = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  // Peripheral clock rate register
  logic [cbt_pkg::CLOCK_W-1:0] clock_hz;

  // Divider hookup
  cbt_pkg::div_req_t div_req;
  cbt_pkg::div_rsp_t div_rsp;

  // Quotient (clocks per bit), held during the search
  logic [cbt_pkg::CLOCK_W-1:0] cpb;

  // Search counters: d, q-1, s-3, plus running products
  logic [3:0]                 d;
  logic [4:0]                 qidx;
  logic [3:0]                 sidx;
  logic [4:0]                 mult;   // d + 1
  logic [cbt_pkg::QM_W-1:0]   qm;     // q * (d + 1)
  logic [cbt_pkg::PROD_W-1:0] prod;   // s * q * (d + 1)

  logic [cbt_pkg::QM_W-1:0]   qm_inc;
  logic [4:0]                 mult_inc;
  logic                       match;

  // Pending result
  logic                       res_found;
  logic [3:0]                 res_div;
  logic [cbt_pkg::WORD_W-1:0] res_word;

  // Timing word fields from the current candidate
  logic [3:0] tseg1;
  logic [2:0] tseg2;
  logic [1:0] sjw;
  logic [cbt_pkg::WORD_W-1:0] word;

  logic accept;
  logic post;

  assign accept = request.valid && request.ready;
  assign request.ready = (state == ST_IDLE);

  // Post when the result register is free or being drained this cycle
  assign post = (state == ST_POST) && (!result.valid || result.ready);

  // Configuration write
  always_ff @(posedge clk) begin
    if (rst) begin
      clock_hz <= cbt_pkg::CLOCK_RESET;
    end else if (cfg_we) begin
      clock_hz <= cfg_data;
    end
  end

  // Kick the divider on a nonzero bit rate
  assign div_req.start = accept && (request.bit_rate != '0);
  assign div_req.dividend = clock_hz;
  assign div_req.divisor = request.bit_rate;

  cbt_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Candidate check: quotient must fit the product width and equal it
  assign match = (cpb[cbt_pkg::CLOCK_W-1:cbt_pkg::PROD_W] == '0) &&
                 (cpb[cbt_pkg::PROD_W-1:0] == prod);

  assign qm_inc = qm + {5'd0, mult};
  assign mult_inc = mult + 5'd1;

  // tseg1 = (s-3)/2, tseg2 = the rest, sjw = min(tseg1, 3)
  assign tseg1 = {1'b0, sidx[3:1]};
  assign tseg2 = sidx[2:0] - tseg1[2:0];
  assign sjw = (tseg1 > {2'b00, cbt_pkg::SJW_MAX}) ? cbt_pkg::SJW_MAX : tseg1[1:0];
  assign word = {tseg2, tseg1, sjw, {1'b0, qidx}};

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (request.bit_rate == '0) ? ST_POST : ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (match || (d == cbt_pkg::DIV_LAST && qidx == cbt_pkg::QIDX_LAST &&
                      sidx == cbt_pkg::SIDX_LAST)) begin
          state_next = ST_POST;
        end
      end
      ST_POST: begin
        if (post) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Search datapath: advance s innermost, then q, then d; products stay
  // incremental so each step needs only an add
  always_ff @(posedge clk) begin
    if (accept) begin
      // Clear the result for the zero-rate and not-found cases
      res_found <= 1'b0;
      res_div <= '0;
      res_word <= '0;
    end
    if (state == ST_DIV && div_rsp.done) begin
      cpb <= div_rsp.quotient;
      d <= '0;
      qidx <= '0;
      sidx <= '0;
      mult <= 5'd1;
      qm <= cbt_pkg::QM_W'(1);
      prod <= cbt_pkg::PROD_W'(3);
    end else if (state == ST_SEARCH) begin
      if (match) begin
        res_found <= 1'b1;
        res_div <= d;
        res_word <= word;
      end else if (sidx != cbt_pkg::SIDX_LAST) begin
        sidx <= sidx + 4'd1;
        prod <= prod + {{(cbt_pkg::PROD_W-cbt_pkg::QM_W){1'b0}}, qm};
      end else if (qidx != cbt_pkg::QIDX_LAST) begin
        qidx <= qidx + 5'd1;
        sidx <= '0;
        qm <= qm_inc;
        prod <= {{(cbt_pkg::PROD_W-cbt_pkg::QM_W-1){1'b0}}, qm_inc, 1'b0} +
                {{(cbt_pkg::PROD_W-cbt_pkg::QM_W){1'b0}}, qm_inc};
      end else if (d != cbt_pkg::DIV_LAST) begin
        d <= d + 4'd1;
        qidx <= '0;
        sidx <= '0;
        mult <= mult_inc;
        qm <= {5'd0, mult_inc};
        prod <= {{(cbt_pkg::PROD_W-6){1'b0}}, mult_inc, 1'b0} +
                {{(cbt_pkg::PROD_W-5){1'b0}}, mult_inc};
      end
    end
  end

  // Result register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (post) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (post) begin
      result.found <= res_found;
      result.clock_divider <= res_div;
      result.timing_word <= res_word;
    end
  end

endmodule

FILE: design/cbt_div.sv
module cbt_div (
  input  logic              clk,
  input  logic              rst,
  input  cbt_pkg::div_req_t req,
  output cbt_pkg::div_rsp_t rsp
);

  logic                        busy;
  logic [4:0]                  count;
  logic [cbt_pkg::CLOCK_W-1:0] shreg;
  logic [cbt_pkg::BAUD_W-1:0]  rem;
  logic [cbt_pkg::BAUD_W-1:0]  divisor;
  logic                        done;

  logic [cbt_pkg::BAUD_W:0]    trial;
  logic                        fits;

  // One restoring step: bring down the next dividend bit, subtract if it fits
  assign trial = {rem, shreg[cbt_pkg::CLOCK_W-1]};
  assign fits = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 5'd1;
        if (count == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      shreg <= req.dividend;
      divisor <= req.divisor;
      rem <= '0;
    end else if (busy) begin
      shreg <= {shreg[cbt_pkg::CLOCK_W-2:0], fits};
      rem <= fits ? trial[cbt_pkg::BAUD_W-1:0] - divisor : trial[cbt_pkg::BAUD_W-1:0];
    end
  end

  assign rsp.done = done;
  assign rsp.quotient = shreg;

endmodule

FILE: design/cbt_checker.sv
module cbt_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_valid,
  input logic                        req_ready,
  input logic                        res_valid,
  input logic                        res_ready,
  input logic                        res_found,
  input logic [cbt_pkg::DIVSEL_W-1:0] res_div,
  input logic [cbt_pkg::WORD_W-1:0]  res_word
);

  // Busy right after taking a request
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request taken while a search was running");

  // A miss carries an all-zero payload
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_found) |-> (res_div == '0 && res_word == '0))
    else $error("nonzero payload on a miss");

  // Segment split: tseg2 equals tseg1 or tseg1 + 1, sjw is min(tseg1, 3)
  a_word_fields: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_found) |->
      (({1'b0, res_word[14:12]} == res_word[11:8] ||
        {1'b0, res_word[14:12]} == res_word[11:8] + 4'd1) &&
       ((res_word[11:8] >= 4'd3 && res_word[7:6] == 2'd3) ||
        (res_word[11:8] < 4'd3 && {2'b00, res_word[7:6]} == res_word[11:8]))))
    else $error("inconsistent timing word");

  // Stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=>
      (res_valid && $stable(res_found) && $stable(res_div) && $stable(res_word)))
    else $error("stalled result changed");

endmodule

bind can_bit_timing_search cbt_checker u_cbt_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (request.valid),
  .req_ready (request.ready),
  .res_valid (result.valid),
  .res_ready (result.ready),
  .res_found (result.found),
  .res_div   (result.clock_divider),
  .res_word  (result.timing_word)
);
